@@ rtl/fire_heat_field_engine_unit_defines.svh @@
// Assertion macros for the fire heat field engine.
// Used by the top level; relies on the clock and reset port names.
`ifndef FIRE_HEAT_FIELD_ENGINE_UNIT_DEFINES_SVH
`define FIRE_HEAT_FIELD_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FHE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FHE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fhe_pkg.sv @@
// Types, codes and constant arithmetic helpers for the fire heat field engine.
// No dependencies.
package fhe_pkg;

   localparam int SPARK_RANGE = 160;
   localparam int PAL_W       = 7;

   localparam logic [1:0] MODE_PROPAGATE = 2'd0;
   localparam logic [1:0] MODE_SPARK     = 2'd1;
   localparam logic [1:0] MODE_RENDER    = 2'd2;

   localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
   localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MASK_ENABLE  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  col;
      logic [3:0]  row;
      logic [15:0] drift_random;
      logic [15:0] decay_random;
      logic [15:0] spark_random;
   } req_type;

   typedef struct packed {
      logic [7:0]       heat_value;
      logic [PAL_W-1:0] palette_index;
      logic             bad_address;
   } rsp_type;

   // x mod 3 through the reciprocal 43691 / 2^17, exact over 16 bits.
   function automatic logic [1:0] mod3_u16(input logic [15:0] x);
      logic [32:0] prod;
      logic [15:0] quot;
      logic [15:0] rem;
      prod = 33'(x) * 33'(43691);
      quot = prod[32:17];
      rem  = x - ((quot << 1) + quot);
      return rem[1:0];
   endfunction

   // x mod 5 through the reciprocal 52429 / 2^18, exact over 16 bits.
   function automatic logic [2:0] mod5_u16(input logic [15:0] x);
      logic [31:0] prod;
      logic [15:0] quot;
      logic [15:0] rem;
      prod = 32'(x) * 32'(52429);
      quot = 16'(prod[31:18]);
      rem  = x - ((quot << 2) + quot);
      return rem[2:0];
   endfunction

   // x mod 160: the low five bits pass through, the rest is divided by 5.
   function automatic logic [7:0] mod160_u16(input logic [15:0] x);
      logic [26:0] prod;
      logic [15:0] quot;
      logic [15:0] rem;
      prod = 27'(x[15:5]) * 27'(52429);
      quot = 16'(prod[26:18]);
      rem  = x - ((quot << 7) + (quot << 5));
      return rem[7:0];
   endfunction

endpackage

@@ rtl/fire_heat_field_engine_unit.sv @@
// Fire heat field engine: heat grid in one synchronous memory, one cell operation per request.
// A taken request is registered in the second stage, then its result in the output register.
// Throughput: one request per cycle unless stalled; the grid has one read and one write port.
// Reset: a clearing pass zeroes the grid's MAX_WIDTH*MAX_HEIGHT cells (256 at default size),
// with req_stall high throughout; the configuration port is live during the pass.
// Depends on fhe_pkg and fire_heat_field_engine_unit_defines.svh.
`include "fire_heat_field_engine_unit_defines.svh"

module fire_heat_field_engine_unit #(
   parameter int MAX_WIDTH    = 16,
   parameter int MAX_HEIGHT   = 16,
   parameter int PALETTE_SIZE = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  fhe_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fhe_pkg::rsp_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);
   import fhe_pkg::*;

   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = $clog2(DEPTH);
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W   = $clog2(MAX_DIM + 32);
   localparam int SQ_W    = 2 * (DIM_W + 1);

   // Configuration registers.
   logic [4:0] panel_width_ff, panel_width_in;
   logic [4:0] panel_height_ff, panel_height_in;
   logic       mask_enable_ff, mask_enable_in;

   // Clearing pass.
   logic          clear_busy_ff, clear_busy_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   // Grid memory.
   logic [7:0]    heat_mem [DEPTH];
   logic [7:0]    mem_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // Request-side decode.
   logic             req_accept;
   logic [DIM_W-1:0] w_sat, h_sat, col_e, row_e, src_col, rd_row, rd_col, wr_row, rad;
   logic [1:0]       drift_pick;
   logic             bad_in;
   logic [2:0]       decay_sub_in;
   logic [7:0]       spark_heat_in;
   logic             masked_in;
   logic [AW-1:0]    rd_addr_in, wr_addr_in;
   logic signed [DIM_W:0] dx_s, dy_s;
   logic signed [SQ_W-1:0] dx_w, dy_w;
   logic [SQ_W-1:0]  dist2;
   logic [SQ_W-1:0]  rad2;

   // Second stage: read data present, result formed.
   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_mode_ff;
   logic          s1_bad_ff;
   logic [AW-1:0] s1_wr_addr_ff;
   logic [2:0]    s1_decay_sub_ff;
   logic [7:0]    s1_spark_heat_ff;
   logic          s1_masked_ff;
   logic          fwd_hit_ff, fwd_hit_in;
   logic [7:0]    fwd_data_ff;
   logic          s1_adv;
   logic          s1_wr_en;
   logic [7:0]    src_heat;
   rsp_type       s1_result;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic [PAL_W-1:0] pal_lut [256];

   for (genvar g = 0; g < 256; g++) begin : g_pal
      localparam int PAL_RAW = g * (PALETTE_SIZE - 1) / SPARK_RANGE;
      localparam int PAL_CLP = (PAL_RAW > PALETTE_SIZE - 1) ? PALETTE_SIZE - 1 : PAL_RAW;
      assign pal_lut[g] = PAL_W'(PAL_CLP);
   end

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;

   always_comb begin
      panel_width_in  = panel_width_ff;
      panel_height_in = panel_height_ff;
      mask_enable_in  = mask_enable_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_PANEL_WIDTH:  panel_width_in  = csr_pwdata[4:0];
            REG_PANEL_HEIGHT: panel_height_in = csr_pwdata[4:0];
            REG_MASK_ENABLE:  mask_enable_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_PANEL_WIDTH:  csr_prdata = 32'(panel_width_ff);
         REG_PANEL_HEIGHT: csr_prdata = 32'(panel_height_ff);
         REG_MASK_ENABLE:  csr_prdata = 32'(mask_enable_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- request decode ----------------
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = clear_busy_ff || (s1_valid_ff && !s1_adv);

   always_comb begin
      if (DIM_W'(panel_width_ff) < DIM_W'(2)) begin
         w_sat = DIM_W'(2);
      end else if (DIM_W'(panel_width_ff) > DIM_W'(MAX_WIDTH)) begin
         w_sat = DIM_W'(MAX_WIDTH);
      end else begin
         w_sat = DIM_W'(panel_width_ff);
      end
      if (DIM_W'(panel_height_ff) < DIM_W'(2)) begin
         h_sat = DIM_W'(2);
      end else if (DIM_W'(panel_height_ff) > DIM_W'(MAX_HEIGHT)) begin
         h_sat = DIM_W'(MAX_HEIGHT);
      end else begin
         h_sat = DIM_W'(panel_height_ff);
      end
   end

   always_comb begin
      col_e      = DIM_W'(req_data.col);
      row_e      = DIM_W'(req_data.row);
      drift_pick = mod3_u16(req_data.drift_random);

      // Lateral source column, held inside the panel.
      case (drift_pick)
         2'd0:    src_col = (col_e == '0) ? '0 : col_e - DIM_W'(1);
         2'd1:    src_col = col_e;
         default: src_col = (col_e + DIM_W'(1) >= w_sat) ? w_sat - DIM_W'(1)
                                                          : col_e + DIM_W'(1);
      endcase

      if (req_data.mode == MODE_PROPAGATE) begin
         rd_row = row_e + DIM_W'(1);
         rd_col = src_col;
      end else begin
         rd_row = row_e;
         rd_col = col_e;
      end
      wr_row = (req_data.mode == MODE_SPARK) ? h_sat - DIM_W'(1) : row_e;

      rd_addr_in = AW'(32'(rd_row) * MAX_WIDTH + 32'(rd_col));
      wr_addr_in = AW'(32'(wr_row) * MAX_WIDTH + 32'(col_e));

      case (req_data.mode)
         MODE_PROPAGATE: bad_in = (col_e >= w_sat) || (row_e + DIM_W'(1) >= h_sat);
         MODE_SPARK:     bad_in = (col_e >= w_sat);
         MODE_RENDER:    bad_in = (col_e >= w_sat) || (row_e >= h_sat);
         default:        bad_in = 1'b1;
      endcase

      // Cooling is stronger in the upper half of the panel.
      decay_sub_in  = (row_e < (h_sat >> 1)) ? mod5_u16(req_data.decay_random)
                                             : 3'(mod3_u16(req_data.decay_random));
      spark_heat_in = mod160_u16(req_data.spark_random);

      // Offsets are widened to the full square width before multiplying.
      dx_s  = $signed({1'b0, col_e}) - $signed({1'b0, w_sat >> 1});
      dy_s  = $signed({1'b0, row_e}) - $signed({1'b0, h_sat >> 1});
      dx_w  = SQ_W'(dx_s);
      dy_w  = SQ_W'(dy_s);
      rad   = ((w_sat < h_sat) ? w_sat : h_sat) >> 1;
      dist2 = SQ_W'($unsigned(dx_w * dx_w)) + SQ_W'($unsigned(dy_w * dy_w));
      rad2  = SQ_W'(rad) * SQ_W'(rad);
      masked_in = mask_enable_ff && (dist2 > rad2);
   end

   // ---------------- second stage ----------------
   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_wr_en = s1_adv && !s1_bad_ff
                     && (s1_mode_ff == MODE_PROPAGATE || s1_mode_ff == MODE_SPARK);

   // The memory read misses a write made at the same edge, so that value is carried alongside.
   assign src_heat = fwd_hit_ff ? fwd_data_ff : mem_rd_ff;

   always_comb begin
      s1_result = '0;
      if (s1_bad_ff) begin
         s1_result.bad_address = 1'b1;
      end else begin
         case (s1_mode_ff)
            MODE_PROPAGATE: begin
               s1_result.heat_value = (src_heat > 8'(s1_decay_sub_ff))
                                      ? src_heat - 8'(s1_decay_sub_ff) : 8'd0;
            end
            MODE_SPARK: begin
               s1_result.heat_value = s1_spark_heat_ff;
            end
            MODE_RENDER: begin
               s1_result.heat_value    = src_heat;
               s1_result.palette_index = s1_masked_ff ? PAL_W'(PALETTE_SIZE)
                                                      : pal_lut[src_heat];
            end
            default: begin
               s1_result.bad_address = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      fwd_hit_in = s1_wr_en && (s1_wr_addr_ff == rd_addr_in);

      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   assign mem_we    = clear_busy_ff || s1_wr_en;
   assign mem_waddr = clear_busy_ff ? clear_addr_ff : s1_wr_addr_ff;
   assign mem_wdata = clear_busy_ff ? 8'd0 : s1_result.heat_value;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= 5'd16;
         panel_height_ff <= 5'd16;
         mask_enable_ff  <= 1'b1;
         clear_busy_ff   <= 1'b1;
         clear_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         panel_width_ff  <= panel_width_in;
         panel_height_ff <= panel_height_in;
         mask_enable_ff  <= mask_enable_in;
         clear_busy_ff   <= clear_busy_in;
         clear_addr_ff   <= clear_addr_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff       <= req_data.mode;
         s1_bad_ff        <= bad_in;
         s1_wr_addr_ff    <= wr_addr_in;
         s1_decay_sub_ff  <= decay_sub_in;
         s1_spark_heat_ff <= spark_heat_in;
         s1_masked_ff     <= masked_in;
         fwd_hit_ff       <= fwd_hit_in;
         fwd_data_ff      <= s1_result.heat_value;
      end
      if (s1_adv) begin
         rsp_data_ff <= s1_result;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heat_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         mem_rd_ff <= heat_mem[rd_addr_in];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   `FHE_ASSERT_NOW(a_no_accept_clearing, clear_busy_ff, !req_accept, "request taken during clearing pass")
   `FHE_ASSERT_NOW(a_no_write_clearing, clear_busy_ff, !s1_wr_en, "cell write during clearing pass")
   `FHE_ASSERT_NEXT(a_accept_fills_s1, req_accept, s1_valid_ff, "accepted request lost before stage two")
   `FHE_ASSERT_NEXT(a_adv_fills_rsp, s1_adv, rsp_valid_ff, "stage two result not registered")
   `FHE_ASSERT_NEXT(a_fwd_taken, req_accept && s1_wr_en && s1_wr_addr_ff == rd_addr_in, fwd_hit_ff, "same-cell write not forwarded")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the fire heat field engine: a clocked driver and monitor
// around the unit, with an in-bench prediction of the heat grid for every request.
// Depends on fhe_pkg and fire_heat_field_engine_unit.
`timescale 1ns / 100ps

module tb_top;
   import fhe_pkg::*;

   localparam int GRID_COLS   = 16;
   localparam int GRID_ROWS   = 16;
   localparam int PAL_SIZE    = 64;
   localparam int CYCLE_LIMIT = 50000;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted copy of the grid and of the panel registers.
   logic [7:0] heat_grid [GRID_COLS*GRID_ROWS];
   logic [4:0] cfg_cols = 5'd16;
   logic [4:0] cfg_rows = 5'd16;
   logic       cfg_mask = 1'b1;

   req_type pending_ops[$];
   rsp_type expected_cells[$];
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      mismatches     = 0;
   int      cycle_count    = 0;

   fire_heat_field_engine_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic int panel_dim(input logic [4:0] v, input int maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   // Applies one cell operation to the predicted grid and returns the result it yields.
   function automatic rsp_type cell_outcome(input req_type rq);
      int      w, h, col, row, src, v, dx, dy, rad, pal;
      rsp_type res;
      w   = panel_dim(cfg_cols, GRID_COLS);
      h   = panel_dim(cfg_rows, GRID_ROWS);
      col = int'(rq.col);
      row = int'(rq.row);
      res = '0;
      case (rq.mode)
         MODE_PROPAGATE: begin
            if (col >= w || row + 1 >= h) begin
               res.bad_address = 1'b1;
            end else begin
               src = col + int'(rq.drift_random) % 3 - 1;
               if (src < 0) src = 0;
               if (src >= w) src = w - 1;
               v = int'(heat_grid[(row + 1) * GRID_COLS + src]);
               if (row < h / 2) v = v - int'(rq.decay_random) % 5;
               else v = v - int'(rq.decay_random) % 3;
               if (v < 0) v = 0;
               res.heat_value = 8'(v);
               heat_grid[row * GRID_COLS + col] = 8'(v);
            end
         end
         MODE_SPARK: begin
            if (col >= w) begin
               res.bad_address = 1'b1;
            end else begin
               res.heat_value = 8'(int'(rq.spark_random) % SPARK_RANGE);
               heat_grid[(h - 1) * GRID_COLS + col] = res.heat_value;
            end
         end
         MODE_RENDER: begin
            if (col >= w || row >= h) begin
               res.bad_address = 1'b1;
            end else begin
               dx  = col - w / 2;
               dy  = row - h / 2;
               rad = ((w < h) ? w : h) / 2;
               res.heat_value = heat_grid[row * GRID_COLS + col];
               pal = int'(res.heat_value) * (PAL_SIZE - 1) / SPARK_RANGE;
               if (pal > PAL_SIZE - 1) pal = PAL_SIZE - 1;
               if (cfg_mask && dx * dx + dy * dy > rad * rad) pal = PAL_SIZE;
               res.palette_index = PAL_W'(pal);
            end
         end
         default: begin
            res.bad_address = 1'b1;
         end
      endcase
      return res;
   endfunction

   function automatic req_type cell_op(input logic [1:0] mode, input int col, input int row,
                                       input int drift, input int decay, input int spark);
      req_type rq;
      rq.mode         = mode;
      rq.col          = 4'(col);
      rq.row          = 4'(row);
      rq.drift_random = 16'(drift);
      rq.decay_random = 16'(decay);
      rq.spark_random = 16'(spark);
      return rq;
   endfunction

   // Mostly well-formed fire traffic inside the panel, with some stray coordinates and
   // the unused mode mixed in.
   function automatic req_type rand_cell_op();
      int      w, h, pick;
      req_type rq;
      w    = panel_dim(cfg_cols, GRID_COLS);
      h    = panel_dim(cfg_rows, GRID_ROWS);
      pick = $urandom_range(99);
      rq.drift_random = 16'($urandom);
      rq.decay_random = 16'($urandom);
      rq.spark_random = 16'($urandom);
      rq.col          = 4'($urandom_range(15));
      rq.row          = 4'($urandom_range(15));
      if (pick < 30) rq.mode = MODE_SPARK;
      else if (pick < 70) rq.mode = MODE_PROPAGATE;
      else if (pick < 95) rq.mode = MODE_RENDER;
      else rq.mode = MODE_UNUSED;
      if (rq.mode != MODE_UNUSED && $urandom_range(9) < 8) begin
         rq.col = 4'($urandom_range(w - 1));
         if (rq.mode == MODE_PROPAGATE) rq.row = 4'($urandom_range(h - 2));
         else if (rq.mode == MODE_RENDER) rq.row = 4'($urandom_range(h - 1));
      end
      return rq;
   endfunction

   // Driver: predicts each accepted request and presents the next one from the queue.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_cells.push_back(cell_outcome(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_ops.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest prediction.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("result with no request outstanding: %p", rsp_data);
               mismatches++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_data.heat_value !== want.heat_value) begin
                  $error("heat_value: expected %0d, got %0d",
                         want.heat_value, rsp_data.heat_value);
                  mismatches++;
               end
               if (rsp_data.palette_index !== want.palette_index) begin
                  $error("palette_index: expected %0d, got %0d",
                         want.palette_index, rsp_data.palette_index);
                  mismatches++;
               end
               if (rsp_data.bad_address !== want.bad_address) begin
                  $error("bad_address: expected %0d, got %0d",
                         want.bad_address, rsp_data.bad_address);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ops.size() != 0 || expected_cells.size() != 0 || req_valid);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value, input int bits);
      logic [31:0] wdata;
      // Bits above the register are filled with noise; only the low ones must count.
      wdata = ($urandom() << bits) | (32'(value) & ((32'd1 << bits) - 32'd1));
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PANEL_WIDTH:  cfg_cols = wdata[4:0];
         REG_PANEL_HEIGHT: cfg_rows = wdata[4:0];
         REG_MASK_ENABLE:  cfg_mask = wdata[0];
         default: ;
      endcase
   endtask

   task automatic set_panel(input int w, input int h, input int m);
      write_reg(REG_PANEL_WIDTH, w, 5);
      write_reg(REG_PANEL_HEIGHT, h, 5);
      write_reg(REG_MASK_ENABLE, m, 1);
   endtask

   task automatic run_phase(input int w, input int h, input int m,
                            input int idle_s, input int idle_r, input int count);
      wait_drained();
      set_panel(w, h, m);
      @(negedge clock);
      send_idle_pct  = idle_s;
      recv_stall_pct = idle_r;
      repeat (count) pending_ops.push_back(rand_cell_op());
   endtask

   initial begin
      foreach (heat_grid[i]) heat_grid[i] = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Full panel with the corner mask: sparks, edge clamping, cooling floor, rendering.
      set_panel(16, 16, 1);
      @(negedge clock);
      pending_ops.push_back(cell_op(MODE_SPARK, 0, 3, 0, 0, 'hFFFF));
      pending_ops.push_back(cell_op(MODE_SPARK, 15, 15, 'hFFFF, 'hFFFF, 159));
      pending_ops.push_back(cell_op(MODE_SPARK, 8, 0, 0, 0, 319));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 0, 14, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 15, 14, 2, 'hFFFF, 0));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 8, 14, 1, 2, 0));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 0, 0, 'hFFFF, 4, 'hFFFF));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 7, 15, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_RENDER, 0, 15, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_RENDER, 8, 14, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_RENDER, 15, 15, 'hFFFF, 'hFFFF, 'hFFFF));
      pending_ops.push_back(cell_op(MODE_RENDER, 8, 8, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_UNUSED, 15, 15, 'hFFFF, 'hFFFF, 'hFFFF));
      pending_ops.push_back(cell_op(MODE_RENDER, 15, 0, 0, 0, 0));

      // Smaller panel without the mask: coordinates outside it are rejected.
      wait_drained();
      set_panel(8, 8, 0);
      @(negedge clock);
      pending_ops.push_back(cell_op(MODE_SPARK, 8, 0, 0, 0, 50));
      pending_ops.push_back(cell_op(MODE_SPARK, 7, 0, 0, 0, 100));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 7, 7, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 7, 6, 2, 5, 0));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 0, 3, 0, 9, 0));
      pending_ops.push_back(cell_op(MODE_RENDER, 8, 0, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_RENDER, 0, 8, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_RENDER, 7, 6, 0, 0, 0));
      pending_ops.push_back(cell_op(MODE_PROPAGATE, 8, 0, 0, 0, 0));

      // The second call holds requests back until every result of the first is in.
      run_phase(16, 16, 1, 59, 0, 50);
      run_phase(16, 16, 1, 59, 0, 50);
      run_phase(2, 2, 0, 0, 59, 60);
      run_phase(0, 31, 1, 24, 24, 60);
      run_phase(5, 9, 1, 0, 0, 80);
      run_phase(17, 1, 0, 59, 59, 60);
      run_phase(31, 0, 1, 0, 59, 40);
      run_phase(16, 16, 1, 24, 24, 100);

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fhe_pkg.sv
rtl/fire_heat_field_engine_unit.sv
dv/tb_top.sv
